### rtl/lrp_pkg.sv
// shared constants for the panel-mapped line rasterizer
`default_nettype none
package lrp_pkg;

  localparam int MOD_LOG     = 3;              // log2 of the 8x8 module size
  localparam int MOD_SIZE    = 1 << MOD_LOG;
  localparam int IDX_W       = 6;              // chain index bits that reach chain_column
  localparam int COL_W       = IDX_W + MOD_LOG;
  localparam int ROW_W       = MOD_LOG;
  localparam int WIDTH_REG_W = 7;
  localparam int COUNT_REG_W = 4;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;              // holds MAX_RESULTS itself

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PANEL_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_PANEL_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_MOD_ACROSS   = 2'd2;
  localparam cfg_idx_t REG_MOD_DOWN     = 2'd3;

  localparam logic [WIDTH_REG_W-1:0] PANEL_WIDTH_RST  = 7'd32;
  localparam logic [WIDTH_REG_W-1:0] PANEL_HEIGHT_RST = 7'd8;
  localparam logic [COUNT_REG_W-1:0] MOD_ACROSS_RST   = 4'd4;
  localparam logic [COUNT_REG_W-1:0] MOD_DOWN_RST     = 4'd1;

endpackage
`default_nettype wire

### rtl/line_rasterizer_panel_mapped.sv
// line rasterizer with pixel mapping onto a chain of 8x8 led modules
// after the input beat a setup state computes the spans and error term, then the walk state loads the first pixel beat
// throughput: one pixel beat per cycle while out_ready holds
// the single error/step unit sets the rate; in_ready is low until the last pixel is loaded
// reset (rst, synchronous): sequencer idle, output empty, panel 32x8 with 4x1 modules
`default_nettype none
module line_rasterizer_panel_mapped import lrp_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  wire                      clk,
  input  wire                      rst,
  // line request channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [COORD_BITS-1:0]    start_x,
  input  wire  [COORD_BITS-1:0]    start_y,
  input  wire  [COORD_BITS-1:0]    end_x,
  input  wire  [COORD_BITS-1:0]    end_y,
  // pixel channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [ROW_W-1:0]         module_row,
  output logic [COL_W-1:0]         chain_column,
  output logic                     visible,
  output logic                     last_point,
  // configuration write port
  input  wire                      cfg_we,
  input  wire  [CFG_IDX_W-1:0]     cfg_index,
  input  wire  [CFG_DATA_W-1:0]    cfg_data
);

  // error term: spans fit in COORD_BITS, doubled error needs two more bits plus sign
  localparam int ERR_W = COORD_BITS + 3;
  // compare width for the visibility test
  localparam int CMP_W = (COORD_BITS > WIDTH_REG_W) ? COORD_BITS : WIDTH_REG_W;

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state;

  // configuration registers
  logic [WIDTH_REG_W-1:0] panel_width;
  logic [WIDTH_REG_W-1:0] panel_height;
  logic [COUNT_REG_W-1:0] mod_across;
  logic [COUNT_REG_W-1:0] mod_down;

  // walk state
  logic [COORD_BITS-1:0]  walk_x;
  logic [COORD_BITS-1:0]  walk_y;
  logic [COORD_BITS-1:0]  target_x;
  logic [COORD_BITS-1:0]  target_y;
  logic [COORD_BITS-1:0]  span_x;
  logic [COORD_BITS-1:0]  span_y;
  logic signed [ERR_W-1:0] step_error;
  logic                   step_left_x;
  logic                   step_up_y;
  logic [CNT_W-1:0]       emit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
      mod_across   <= MOD_ACROSS_RST;
      mod_down     <= MOD_DOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_PANEL_HEIGHT: panel_height <= cfg_data[WIDTH_REG_W-1:0];
        REG_MOD_ACROSS:   mod_across   <= cfg_data[COUNT_REG_W-1:0];
        REG_MOD_DOWN:     mod_down     <= cfg_data[COUNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared step unit: one bresenham error update per pixel
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0] dx_s;
  logic signed [ERR_W-1:0] dy_s;
  logic signed [ERR_W:0]   e2;
  logic                    take_x;
  logic                    take_y;
  logic signed [ERR_W-1:0] step_error_next;
  logic [COORD_BITS-1:0]   walk_x_next;
  logic [COORD_BITS-1:0]   walk_y_next;
  logic                    at_end;

  assign dx_s   = $signed({{(ERR_W-COORD_BITS){1'b0}}, span_x});
  assign dy_s   = $signed({{(ERR_W-COORD_BITS){1'b0}}, span_y});
  assign e2     = {step_error, 1'b0};
  // signed compares against the sign-extended spans
  assign take_x = e2 > -$signed({dy_s[ERR_W-1], dy_s});
  assign take_y = e2 < $signed({dx_s[ERR_W-1], dx_s});
  assign at_end = (walk_x == target_x) && (walk_y == target_y);

  always_comb begin
    step_error_next = step_error;
    if (take_x) step_error_next = step_error_next - dy_s;
    if (take_y) step_error_next = step_error_next + dx_s;
    walk_x_next = walk_x;
    if (take_x) walk_x_next = step_left_x ? walk_x - 1'b1 : walk_x + 1'b1;
    walk_y_next = walk_y;
    if (take_y) walk_y_next = step_up_y ? walk_y + 1'b1 : walk_y - 1'b1;
  end

  // ---------------------------------------------------------------------------
  // panel mapping of the current pixel
  // ---------------------------------------------------------------------------
  logic                  pix_visible;
  logic [IDX_W-1:0]      mod_x;
  logic [IDX_W-1:0]      mod_y;
  logic [IDX_W-1:0]      across_ext;
  logic [IDX_W-1:0]      down_ext;
  logic [IDX_W-1:0]      chain_idx;
  logic [ROW_W-1:0]      local_col;
  logic [ROW_W-1:0]      local_row;

  assign pix_visible = (CMP_W'(walk_x) < CMP_W'(panel_width))
                    && (CMP_W'(walk_y) < CMP_W'(panel_height));
  assign mod_x      = IDX_W'(walk_x >> MOD_LOG);
  assign mod_y      = IDX_W'(walk_y >> MOD_LOG);
  assign across_ext = IDX_W'(mod_across);
  assign down_ext   = IDX_W'(mod_down);
  // chain runs right to left, top to bottom; only the low index bits survive
  assign chain_idx  = IDX_W'((down_ext - 1'b1 - mod_y) * across_ext)
                    + (across_ext - 1'b1 - mod_x);
  // mirror within the module
  assign local_col  = ~walk_x[ROW_W-1:0];
  assign local_row  = ~walk_y[ROW_W-1:0];

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  logic out_free;
  logic load_pixel;
  logic walk_done;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign load_pixel = (state == ST_WALK) && out_free;
  // stop at the end point, or when the result cap is reached
  assign walk_done  = at_end || (emit_count == CNT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      emit_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state      <= ST_SETUP;
            emit_count <= '0;
          end
        end
        ST_SETUP: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (out_free) begin
            emit_count <= emit_count + 1'b1;
            if (walk_done) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_pixel) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      walk_x      <= start_x;
      walk_y      <= start_y;
      target_x    <= end_x;
      target_y    <= end_y;
      step_left_x <= !(start_x < end_x);
      step_up_y   <= start_y < end_y;
    end else if (state == ST_SETUP) begin
      // absolute spans and the starting error term span_x - span_y
      span_x <= step_left_x ? walk_x - target_x : target_x - walk_x;
      span_y <= step_up_y ? target_y - walk_y : walk_y - target_y;
      step_error <= $signed({{(ERR_W-COORD_BITS){1'b0}},
                             step_left_x ? walk_x - target_x : target_x - walk_x})
                  - $signed({{(ERR_W-COORD_BITS){1'b0}},
                             step_up_y ? target_y - walk_y : walk_y - target_y});
    end else if (load_pixel) begin
      walk_x     <= walk_x_next;
      walk_y     <= walk_y_next;
      step_error <= step_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pixel) begin
      visible      <= pix_visible;
      last_point   <= at_end;
      module_row   <= pix_visible ? local_row : '0;
      chain_column <= pix_visible ? {chain_idx, local_col} : '0;
    end
  end

endmodule
`default_nettype wire

### verif/line_rasterizer_panel_mapped_tb.sv
// testbench for the panel-mapped line rasterizer: directed and random lines over several panel setups
module line_rasterizer_panel_mapped_tb import lrp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 6;                         // coordinate bits of the block
  localparam longint RUN_LIMIT_NS = 64'd60_000_000;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             vis;
    logic             last;
  } pixel_t;

  // expected pixel beats for every accepted line, plus a private copy of the panel registers
  class line_pixel_board;
    pixel_t                 expected_pixels[$];
    logic [WIDTH_REG_W-1:0] width_px;
    logic [WIDTH_REG_W-1:0] height_px;
    logic [COUNT_REG_W-1:0] across;
    logic [COUNT_REG_W-1:0] down;
    int errors;
    int lines;
    int beats;
    int dark_beats;
    int setups;

    function new();
      width_px  = PANEL_WIDTH_RST;
      height_px = PANEL_HEIGHT_RST;
      across    = MOD_ACROSS_RST;
      down      = MOD_DOWN_RST;
      errors = 0;
      lines = 0;
      beats = 0;
      dark_beats = 0;
      setups = 1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PANEL_WIDTH:  width_px  = value[WIDTH_REG_W-1:0];
        REG_PANEL_HEIGHT: height_px = value[WIDTH_REG_W-1:0];
        REG_MOD_ACROSS:   across    = value[COUNT_REG_W-1:0];
        REG_MOD_DOWN:     down      = value[COUNT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function pixel_t panel_pixel(coord_t x, coord_t y, logic last);
      pixel_t p;
      int unsigned chain_idx;
      int unsigned full_col;
      p = '0;
      p.last = last;
      p.vis = (32'(x) < 32'(width_px)) && (32'(y) < 32'(height_px));
      if (p.vis) begin
        // modules run right to left and top to bottom, wrapping when the grid is too small
        chain_idx = (32'(down) - 32'd1 - 32'(y) / MOD_SIZE) * 32'(across)
                  + (32'(across) - 32'd1 - 32'(x) / MOD_SIZE);
        full_col  = chain_idx * MOD_SIZE + (MOD_SIZE - 1 - 32'(x) % MOD_SIZE);
        p.row = ROW_W'(MOD_SIZE - 1 - 32'(y) % MOD_SIZE);
        p.col = full_col[COL_W-1:0];
      end
      return p;
    endfunction

    // bresenham walk of one accepted line, start and end both included
    function void note_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      coord_t wx, wy;
      logic   go_left, go_up, at_end, done;
      int     span_x, span_y, err, e2, count;
      wx = sx;
      wy = sy;
      go_left = !(wx < ex);
      go_up   = wy < ey;
      span_x = go_left ? int'(wx) - int'(ex) : int'(ex) - int'(wx);
      span_y = go_up   ? int'(ey) - int'(wy) : int'(wy) - int'(ey);
      err = span_x - span_y;
      count = 0;
      done = 1'b0;
      while (!done && count < MAX_RESULTS) begin
        at_end = (wx == ex) && (wy == ey);
        expected_pixels.push_back(panel_pixel(wx, wy, at_end));
        count++;
        if (at_end) begin
          done = 1'b1;
        end else begin
          e2 = 2 * err;
          if (e2 > -span_y) begin
            err -= span_y;
            wx = go_left ? wx - 1'b1 : wx + 1'b1;
          end
          if (e2 < span_x) begin
            err += span_x;
            wy = go_up ? wy + 1'b1 : wy - 1'b1;
          end
        end
      end
      lines++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel beat: expected none, got row %0d col %0d vis %0d last %0d",
                 $time, got.row, got.col, got.vis, got.last);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      beats++;
      if (!want.vis) dark_beats++;
      if (got.row !== want.row) begin
        $display("%0t module_row mismatch: expected %0d, got %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $display("%0t chain_column mismatch: expected %0d, got %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.vis !== want.vis) begin
        $display("%0t visible mismatch: expected %0d, got %0d", $time, want.vis, got.vis);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t last_point mismatch: expected %0d, got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  coord_t                start_x = '0;
  coord_t                start_y = '0;
  coord_t                end_x = '0;
  coord_t                end_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_W-1:0]      module_row;
  logic [COL_W-1:0]      chain_column;
  logic                  visible;
  logic                  last_point;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_pixel_board board = new();

  // knobs shared between the line sender and the pixel receiver
  bit sender_calm = 1'b0;   // no gaps between line beats
  bit ready_calm = 1'b0;    // receiver never stalls
  bit hold_request = 1'b0;  // ask the receiver for one long hold-off
  int hold_left = 0;

  line_rasterizer_panel_mapped #(.COORD_BITS(CW)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .module_row   (module_row),
    .chain_column (chain_column),
    .visible      (visible),
    .last_point   (last_point),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // safety net in case the block hangs or drops a beat
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d pixel beats still expected", board.pending());
    $display("status: fail");
    $finish;
  end

  // pixel receiver: checks each accepted beat, then picks the next ready value
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_pixel('{row: module_row, col: chain_column, vis: visible, last: last_point});
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        // long hold-off so the block fills and drops in_ready
        hold_request = 1'b0;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (ready_calm) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 249) == 0) begin
        hold_left <= $urandom_range(15, 50);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // idle cycles before the next line beat: mostly none or a few, now and then a long one
  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 45);
  endfunction

  // offer one line beat and hold it until accepted; returns just after the accepting edge
  task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_line(sx, sy, ex, ey);
  endtask

  // random line: often anywhere, some short, some flat, steep or a single point
  task automatic send_random(int hi);
    coord_t sx, sy, ex, ey;
    int mode;
    sx = coord_t'($urandom_range(0, hi));
    sy = coord_t'($urandom_range(0, hi));
    ex = coord_t'($urandom_range(0, hi));
    ey = coord_t'($urandom_range(0, hi));
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        // short line, wrapping is fine since any endpoint is legal
        ex = sx + coord_t'($urandom_range(0, 14)) - coord_t'(7);
        ey = sy + coord_t'($urandom_range(0, 14)) - coord_t'(7);
      end
      3: ey = sy;
      4: ex = sx;
      5: begin
        ex = sx;
        ey = sy;
      end
      default: ;
    endcase
    send_line(sx, sy, ex, ey);
  endtask

  // stop offering lines until every expected pixel beat is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // write all four panel registers back to back while the block is idle
  task automatic set_panel(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    cfg_idx_t idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    wait_drained();
    idx = '{REG_PANEL_WIDTH, REG_PANEL_HEIGHT, REG_MOD_ACROSS, REG_MOD_DOWN};
    val = '{w, h, a, d};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      board.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    board.setups++;
  endtask

  initial begin
    coord_t directed [21][4];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed lines on the reset panel (32x8, four modules across one row)
    directed = '{
      '{6'd0,  6'd0,  6'd0,  6'd0},    // single point at the origin
      '{6'd63, 6'd63, 6'd63, 6'd63},   // single point far off the panel
      '{6'd0,  6'd0,  6'd63, 6'd0},    // flat, rightward, crosses the width edge
      '{6'd63, 6'd7,  6'd0,  6'd7},    // flat, leftward on the top visible row
      '{6'd5,  6'd0,  6'd5,  6'd63},   // vertical, upward
      '{6'd5,  6'd63, 6'd5,  6'd0},    // vertical, downward
      '{6'd0,  6'd0,  6'd63, 6'd63},   // full diagonal
      '{6'd63, 6'd63, 6'd0,  6'd0},
      '{6'd63, 6'd0,  6'd0,  6'd63},
      '{6'd0,  6'd63, 6'd63, 6'd0},
      '{6'd0,  6'd0,  6'd31, 6'd7},    // shallow, spans every module
      '{6'd31, 6'd7,  6'd0,  6'd0},
      '{6'd3,  6'd0,  6'd7,  6'd40},   // steep
      '{6'd7,  6'd40, 6'd3,  6'd0},
      '{6'd31, 6'd0,  6'd32, 6'd7},    // straddles the last visible column
      '{6'd0,  6'd7,  6'd0,  6'd8},    // straddles the last visible row
      '{6'd2,  6'd3,  6'd9,  6'd3},    // crosses a module border
      '{6'd40, 6'd5,  6'd45, 6'd2},
      '{6'd8,  6'd1,  6'd7,  6'd6},
      '{6'd21, 6'd42, 6'd42, 6'd21},
      '{6'd16, 6'd4,  6'd24, 6'd4}
    };
    foreach (directed[i])
      send_line(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);

    // largest sensible panel: 8x8 modules
    set_panel(7'd64, 7'd64, 7'd8, 7'd8);
    repeat (20) send_random(63);
    // receiver holds off while lines keep coming back to back
    sender_calm = 1'b1;
    hold_request = 1'b1;
    repeat (12) send_random(63);
    sender_calm = 1'b0;
    repeat (30) send_random(63);
    // sender pauses until the pipe is empty
    wait_drained();
    repeat (40) send_random(63);

    // zero width: nothing visible
    set_panel(7'd0, 7'd127, 7'd0, 7'd15);
    repeat (25) send_random(63);

    // zero modules with a full extent: chain index wraps
    set_panel(7'd64, 7'd64, 7'd0, 7'd0);
    repeat (30) send_random(63);

    // one pixel panel, lines kept near the origin
    set_panel(7'd1, 7'd1, 7'd1, 7'd1);
    repeat (30) send_random(7);

    // register maxima, no idling on either side
    ready_calm = 1'b1;
    sender_calm = 1'b1;
    set_panel(7'd127, 7'd127, 7'd127, 7'd127);
    repeat (50) send_random(63);
    ready_calm = 1'b0;
    sender_calm = 1'b0;

    // random register values, module fields get their unused upper bits too
    repeat (3) begin
      set_panel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      repeat (35) send_random(63);
    end

    wait_drained();
    // a late stray beat would show up as unexpected here
    repeat (16) @(posedge clk);
    $display("ran %0d lines over %0d panel setups: %0d pixel beats checked, %0d off the panel",
             board.lines, board.setups, board.beats, board.dark_beats);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
